@@ rtl/core/dttf_pkg.sv @@
// Package for the decimal text to fixed point unit.
// Parser phase type, ASCII codes and the status flag group. No dependencies.
`default_nettype none

package dttf_pkg;

    typedef enum logic [1:0] {
        PH_START,
        PH_INT,
        PH_FRAC,
        PH_STOP
    } phase_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int FRAC_CNT_W = 4;

    typedef struct packed {
        logic negative;
        logic clamped;
        logic stopped;
    } dttf_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/dttf_parser.sv @@
// Parser state and per-character update, plus the clamped magnitude of the
// number parsed so far. Depends on dttf_pkg.
`default_nettype none

module dttf_parser #(
    parameter int MAX_FRAC_DIGITS = 8,
    parameter int INT_BITS        = 23,
    parameter int FRAC_BITS       = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [7:0]                    character,
    output logic [INT_BITS+FRAC_BITS-1:0]      mag,
    output dttf_pkg::dttf_flags_t              flags
);
    import dttf_pkg::*;

    localparam int MAG_W = INT_BITS + FRAC_BITS;

    localparam logic [FRAC_BITS-1:0] WEIGHT [8] = '{
        FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10),
        FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100),
        FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000),
        FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000),
        FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000),
        FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000),
        FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd5000000) / 64'd10000000),
        FRAC_BITS'(((64'd1 << FRAC_BITS) + 64'd50000000) / 64'd100000000)
    };

    phase_t                  phase_reg, phase_next;
    logic                    negative_reg, negative_next;
    logic [INT_BITS-1:0]     int_reg, int_next;
    logic [FRAC_BITS:0]      frac_reg, frac_next;
    logic [FRAC_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                    clamp_reg, clamp_next;
    logic                    stop_reg, stop_next;

    logic                    is_digit;
    logic [3:0]              digit;
    logic [INT_BITS+3:0]     int_prod;
    logic                    int_over;
    logic [FRAC_BITS+4:0]    frac_term;
    logic [FRAC_BITS+4:0]    frac_sum;
    logic [INT_BITS:0]       int_total;

    assign is_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
    assign digit     = 4'(character - CH_ZERO);
    assign int_prod  = (INT_BITS+4)'(int_reg) * (INT_BITS+4)'(10) + (INT_BITS+4)'(digit);
    assign int_over  = int_prod[INT_BITS+3:INT_BITS] != 4'd0;
    assign frac_term = (FRAC_BITS+5)'(digit) * (FRAC_BITS+5)'(WEIGHT[cnt_reg[2:0]]);
    assign frac_sum  = (FRAC_BITS+5)'(frac_reg) + frac_term;

    always_comb
    begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        int_next      = int_reg;
        frac_next     = frac_reg;
        cnt_next      = cnt_reg;
        clamp_next    = clamp_reg;
        stop_next     = stop_reg;
        if (step)
        begin
            if (character == CH_NUL)
            begin
                phase_next    = PH_START;
                negative_next = 1'b0;
                int_next      = '0;
                frac_next     = '0;
                cnt_next      = '0;
                clamp_next    = 1'b0;
                stop_next     = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START, PH_INT:
                    begin
                        if (is_digit)
                        begin
                            phase_next = PH_INT;
                            if (int_over)
                            begin
                                int_next   = '1;
                                clamp_next = 1'b1;
                            end
                            else
                            begin
                                int_next = int_prod[INT_BITS-1:0];
                            end
                        end
                        else if (character == CH_POINT)
                        begin
                            phase_next = PH_FRAC;
                        end
                        else if (phase_reg == PH_START && character == CH_MINUS)
                        begin
                            phase_next    = PH_INT;
                            negative_next = 1'b1;
                        end
                        else if (phase_reg == PH_START && character == CH_PLUS)
                        begin
                            phase_next = PH_INT;
                        end
                        else
                        begin
                            phase_next = PH_STOP;
                            stop_next  = 1'b1;
                        end
                    end
                    PH_FRAC:
                    begin
                        if (is_digit)
                        begin
                            if (cnt_reg < FRAC_CNT_W'(MAX_FRAC_DIGITS))
                            begin
                                cnt_next  = cnt_reg + 1'b1;
                                frac_next = frac_sum[FRAC_BITS:0];
                            end
                        end
                        else
                        begin
                            phase_next = PH_STOP;
                            stop_next  = 1'b1;
                        end
                    end
                    PH_STOP:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            negative_reg <= 1'b0;
            int_reg      <= '0;
            frac_reg     <= '0;
            cnt_reg      <= '0;
            clamp_reg    <= 1'b0;
            stop_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            int_reg      <= int_next;
            frac_reg     <= frac_next;
            cnt_reg      <= cnt_next;
            clamp_reg    <= clamp_next;
            stop_reg     <= stop_next;
        end
    end

    // fraction carry goes into the integer part; overflow clamps to all ones
    assign int_total = (INT_BITS+1)'(int_reg) + (INT_BITS+1)'(frac_reg[FRAC_BITS]);
    assign mag = int_total[INT_BITS] ? {MAG_W{1'b1}}
                                     : {int_total[INT_BITS-1:0], frac_reg[FRAC_BITS-1:0]};

    assign flags.negative = negative_reg;
    assign flags.clamped  = clamp_reg;
    assign flags.stopped  = stop_reg;

endmodule

`default_nettype wire

@@ rtl/core/dttf_out_reg.sv @@
// Result register: applies the sign, truncates to 48 bits and holds the item
// until taken. Depends on dttf_pkg.
`default_nettype none

module dttf_out_reg #(
    parameter int MAG_W = 47
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire logic [MAG_W-1:0]       mag,
    input  wire dttf_pkg::dttf_flags_t  flags,
    input  wire logic                   out_ready,
    output logic                        free,
    output logic                        out_valid,
    output logic signed [47:0]          value,
    output logic                        saturated,
    output logic                        stopped_early
);
    import dttf_pkg::*;

    logic        valid_reg, valid_next;
    logic [47:0] value_reg;
    logic        sat_reg;
    logic        stop_reg;
    logic [63:0] mag_ext;
    logic [63:0] signed_val;

    assign mag_ext    = 64'(mag);
    assign signed_val = flags.negative ? (64'd0 - mag_ext) : mag_ext;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= signed_val[47:0];
            sat_reg   <= flags.clamped;
            stop_reg  <= flags.stopped;
        end
    end

    assign out_valid     = valid_reg;
    assign value         = value_reg;
    assign saturated     = sat_reg;
    assign stopped_early = stop_reg;

endmodule

`default_nettype wire

@@ rtl/core/decimal_text_to_fixed_point_unit.sv @@
// Top level of the decimal text to fixed point unit: input register, parser,
// result register. Depends on dttf_pkg, dttf_parser and dttf_out_reg.
//
// One ASCII character per item, one item per cycle. A character waits in the
// input register, then updates the parser state (a multiply by ten and add
// for the integer part, a digit times a constant weight for the fraction).
// A NUL character leaving the input register loads the result register, which
// then holds its result item; all other characters produce none. Only a NUL
// that finds the result register still occupied stalls the input. The result
// is signed fixed point with FRAC_BITS fraction bits in a 48-bit field.
`default_nettype none

module decimal_text_to_fixed_point_unit #(
    parameter int MAX_FRAC_DIGITS = 8,
    parameter int INT_BITS        = 23,
    parameter int FRAC_BITS       = 24
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          character,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [47:0]       value,
    output logic                     saturated,
    output logic                     stopped_early
);
    import dttf_pkg::*;

    localparam int MAG_W = INT_BITS + FRAC_BITS;

    logic                 s1_valid_reg, s1_valid_next;
    logic [7:0]           s1_char_reg;
    logic                 s1_is_nul;
    logic                 s1_go;
    logic                 out_free;
    logic [MAG_W-1:0]     mag;
    dttf_flags_t          flags;

    assign s1_is_nul     = s1_char_reg == CH_NUL;
    assign s1_go         = s1_valid_reg && (!s1_is_nul || out_free);
    assign in_ready      = !s1_valid_reg || s1_go;
    assign s1_valid_next = (in_valid && in_ready) || (s1_valid_reg && !s1_go);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_char_reg <= character;
        end
    end

    dttf_parser #(
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
        .INT_BITS(INT_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .step(s1_go),
        .character(s1_char_reg),
        .mag(mag),
        .flags(flags)
    );

    dttf_out_reg #(
        .MAG_W(MAG_W)
    ) u_out (
        .clk(clk),
        .rst_n(rst_n),
        .load(s1_go && s1_is_nul),
        .mag(mag),
        .flags(flags),
        .out_ready(out_ready),
        .free(out_free),
        .out_valid(out_valid),
        .value(value),
        .saturated(saturated),
        .stopped_early(stopped_early)
    );

endmodule

`default_nettype wire

@@ rtl/core/dttf_checker.sv @@
// Port-level checks for the decimal text to fixed point unit, bound to the
// top level. Depends on decimal_text_to_fixed_point_unit ports only.
`default_nettype none

module dttf_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic [7:0]         character,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [47:0] value,
    input wire logic               saturated,
    input wire logic               stopped_early
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value)
            && $stable(saturated) && $stable(stopped_early))
        else $error("stalled result changed");

    // input only stalls behind a pending result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with result register empty");

    // a clamped integer part can never give a zero value
    a_sat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> value != 48'sd0)
        else $error("saturated result is zero");

endmodule

bind decimal_text_to_fixed_point_unit dttf_checker u_chk (.*);

`default_nettype wire
